// ===== src/cfcr_pkg.sv =====
// Shared types, constants and CRC function of the command frame check and reply core.
package cfcr_pkg;

    localparam int ByteW      = 8;
    localparam int CrcW       = 16;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);
    localparam int IdxW       = 4;

    localparam logic [CrcW-1:0]  CRC_POLY     = 16'h8408;
    localparam logic [CrcW-1:0]  CRC_PRESET   = 16'hFFFF;
    localparam logic [ByteW-1:0] ADDR_BCAST   = 8'hFF;
    localparam logic [ByteW-1:0] MIN_LENGTH   = 8'd4;
    localparam logic [ByteW-1:0] ERR_CODE     = 8'hFE;
    localparam logic [ByteW-1:0] SHORT_LEN    = 8'h05;
    localparam logic [ByteW-1:0] INFO_LEN     = 8'h0D;
    localparam logic [ByteW-1:0] FILL_BYTE    = 8'hFF;

    localparam logic [ByteW-1:0] CMD_03 = 8'h03;
    localparam logic [ByteW-1:0] CMD_21 = 8'h21;
    localparam logic [ByteW-1:0] CMD_22 = 8'h22;
    localparam logic [ByteW-1:0] CMD_24 = 8'h24;
    localparam logic [ByteW-1:0] CMD_25 = 8'h25;
    localparam logic [ByteW-1:0] CMD_28 = 8'h28;
    localparam logic [ByteW-1:0] CMD_2F = 8'h2F;

    localparam logic [ByteW-1:0] INFO_B4 = 8'h03;
    localparam logic [ByteW-1:0] INFO_B5 = 8'h3F;
    localparam logic [ByteW-1:0] INFO_B6 = 8'h09;
    localparam logic [ByteW-1:0] INFO_B7 = 8'h03;
    localparam logic [ByteW-1:0] INFO_B8 = 8'h3E;

    localparam logic [IdxW-1:0] SHORT_LAST = 4'd5;
    localparam logic [IdxW-1:0] INFO_LAST  = 4'd13;

    typedef enum logic [1:0] {
        K_ERR  = 2'd0,
        K_OK   = 2'd1,
        K_INFO = 2'd2
    } t_reply_kind;

    typedef struct packed {
        t_reply_kind      kind;
        logic [ByteW-1:0] cmd;
        logic [ByteW-1:0] mode;
    } t_reply;

    function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
        for (int k = 0; k < ByteW; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/cfcr_front.sv =====
// Frame parser: tracks position and CRC of received bytes and issues reply descriptors.
module cfcr_front
    import cfcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_rx_byte,
    input  logic [ByteW-1:0] i_own_address,
    output logic             o_push,
    output t_reply           o_reply
);

    logic [ByteW-1:0] r_pos, n_pos;
    logic [ByteW-1:0] r_len, n_len;
    logic [CrcW-1:0]  r_crc, n_crc;
    logic [CrcW-1:0]  r_body_crc, n_body_crc;
    logic [ByteW-1:0] r_crc_low, n_crc_low;
    logic             r_addr_ok, n_addr_ok;
    logic [ByteW-1:0] r_cmd, n_cmd;
    logic [ByteW-1:0] r_first, n_first;
    logic [ByteW-1:0] r_mode, n_mode;

    logic good;
    logic known;

    always_comb begin
        good  = r_addr_ok && (r_crc_low == r_body_crc[ByteW-1:0])
                && (i_rx_byte == r_body_crc[CrcW-1:ByteW]);
        known = (r_cmd == CMD_03) || (r_cmd == CMD_21) || (r_cmd == CMD_22)
                || (r_cmd == CMD_24) || (r_cmd == CMD_25) || (r_cmd == CMD_28)
                || (r_cmd == CMD_2F);

        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_body_crc = r_body_crc;
        n_crc_low  = r_crc_low;
        n_addr_ok  = r_addr_ok;
        n_cmd      = r_cmd;
        n_first    = r_first;
        n_mode     = r_mode;
        o_push     = 1'b0;
        o_reply    = '{kind: K_ERR, cmd: r_cmd, mode: r_mode};

        if (i_accept) begin
            if (r_pos == '0) begin
                n_len = i_rx_byte;
                if (i_rx_byte < MIN_LENGTH) begin
                    o_push = 1'b1;
                end else begin
                    n_crc = crc_feed(CRC_PRESET, i_rx_byte);
                    n_pos = 8'd1;
                end
            end else begin
                if (r_pos == 8'd1) begin
                    n_addr_ok = (i_rx_byte == i_own_address) || (i_rx_byte == ADDR_BCAST);
                end
                if (r_pos == 8'd2) begin
                    n_cmd = i_rx_byte;
                end
                if (r_pos == 8'd3) begin
                    n_first = i_rx_byte;
                end
                if (r_pos == r_len) begin
                    o_push = 1'b1;
                    n_pos  = '0;
                    if (good && known) begin
                        o_reply.kind = (r_cmd == CMD_21) ? K_INFO : K_OK;
                    end
                    if (good && (r_cmd == CMD_2F)) begin
                        n_mode = r_first;
                    end
                end else begin
                    if (r_pos == r_len - 8'd1) begin
                        n_body_crc = r_crc;
                        n_crc_low  = i_rx_byte;
                    end else begin
                        n_crc = crc_feed(r_crc, i_rx_byte);
                    end
                    n_pos = r_pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_crc      <= CRC_PRESET;
            r_body_crc <= CRC_PRESET;
            r_crc_low  <= '0;
            r_addr_ok  <= 1'b0;
            r_cmd      <= '0;
            r_first    <= '0;
            r_mode     <= '0;
        end else begin
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_crc      <= n_crc;
            r_body_crc <= n_body_crc;
            r_crc_low  <= n_crc_low;
            r_addr_ok  <= n_addr_ok;
            r_cmd      <= n_cmd;
            r_first    <= n_first;
            r_mode     <= n_mode;
        end
    end

endmodule

// ===== src/cfcr_queue.sv =====
// Short first-word-fallthrough queue of reply descriptors between parser and sender.
module cfcr_queue
    import cfcr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_reply i_data,
    input  logic   i_pop,
    output t_reply o_data,
    output logic   o_empty,
    output logic   o_full
);

    t_reply               r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wptr, n_wptr;
    logic [QueuePtrW-1:0] r_rptr, n_rptr;
    logic [QueueCntW-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QueueCntW'(QueueDepth));
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/cfcr_back.sv =====
// Reply sender: serialises one reply descriptor into bytes with a trailing CRC.
module cfcr_back
    import cfcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_reply           i_reply,
    input  logic [ByteW-1:0] i_own_address,
    output logic             o_pop,
    output logic             o_tx_valid,
    input  logic             i_tx_stall,
    output logic [ByteW-1:0] o_tx_byte,
    output logic             o_tx_last
);

    logic             r_busy, n_busy;
    logic [IdxW-1:0]  r_idx, n_idx;
    logic [CrcW-1:0]  r_crc, n_crc;
    t_reply           r_desc;
    logic             r_valid, n_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_last;

    logic             advance;
    logic [IdxW-1:0]  last_idx;
    logic [ByteW-1:0] body_byte;
    logic [ByteW-1:0] cur_byte;
    logic             is_last;

    assign o_tx_valid = r_valid;
    assign o_tx_byte  = r_byte;
    assign o_tx_last  = r_last;
    assign o_pop      = !r_busy && !i_empty;
    assign advance    = r_busy && (!r_valid || !i_tx_stall);
    assign last_idx   = (r_desc.kind == K_INFO) ? INFO_LAST : SHORT_LAST;
    assign is_last    = (r_idx == last_idx);

    always_comb begin
        body_byte = '0;
        case (r_idx)
            4'd0:    body_byte = (r_desc.kind == K_INFO) ? INFO_LEN : SHORT_LEN;
            4'd1:    body_byte = i_own_address;
            4'd2:    body_byte = (r_desc.kind == K_ERR) ? 8'h00 : r_desc.cmd;
            4'd3:    body_byte = (r_desc.kind == K_ERR) ? ERR_CODE : 8'h00;
            4'd4:    body_byte = INFO_B4;
            4'd5:    body_byte = INFO_B5;
            4'd6:    body_byte = INFO_B6;
            4'd7:    body_byte = INFO_B7;
            4'd8:    body_byte = INFO_B8;
            4'd9:    body_byte = 8'h00;
            4'd10:   body_byte = r_desc.mode;
            4'd11:   body_byte = FILL_BYTE;
            default: body_byte = '0;
        endcase
    end

    always_comb begin
        if (is_last) begin
            cur_byte = r_crc[CrcW-1:ByteW];
        end else if (r_idx == last_idx - 4'd1) begin
            cur_byte = r_crc[ByteW-1:0];
        end else begin
            cur_byte = body_byte;
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_crc   = r_crc;
        n_valid = r_valid;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_crc  = CRC_PRESET;
        end
        if (advance) begin
            n_valid = 1'b1;
            n_idx   = r_idx + 4'd1;
            if (r_idx < last_idx - 4'd1) begin
                n_crc = crc_feed(r_crc, body_byte);
            end
            if (is_last) begin
                n_busy = 1'b0;
            end
        end else if (!i_tx_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_reply;
        end
        if (advance) begin
            r_byte <= cur_byte;
            r_last <= is_last;
        end
        r_idx <= n_idx;
        r_crc <= n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

endmodule

// ===== src/command_frame_check_and_reply_core.sv =====
// Top level of the command frame check and reply core.
//
// Receive channel: one frame byte per transfer on i_rx_byte (i_rx_valid, o_rx_stall).
// Frames are length, address, command, data, CRC low, CRC high; CRC-16 reflected
// (poly 0x8408, preset 0xFFFF). Transmit channel: one reply byte per transfer on
// o_tx_byte with o_tx_last on the CRC high byte (o_tx_valid, i_tx_stall).
// Configuration: i_cfg_own_address is written on i_cfg_valid; o_cfg_ready is always high.
// Write it only while no reply is pending.
// Throughput: one received byte per cycle while the descriptor queue (2 entries) has room.
// A reply of 6 or 14 bytes leaves at one byte per cycle unless i_tx_stall holds a byte;
// o_tx_valid drops between replies unless the next is popped while the last byte stalls.
// Each reply descriptor is queued, popped by the idle sender, then sent from a byte register.
// When the receiver stalls, the current byte holds; parsing continues until the queue
// fills, then o_rx_stall rises.
// Reset (i_rst_n low, synchronous): parser waits for a length byte, mode and address
// clear to zero, queue and sender empty.
module command_frame_check_and_reply_core
    import cfcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    output logic             o_rx_stall,
    input  logic [ByteW-1:0] i_rx_byte,
    output logic             o_tx_valid,
    input  logic             i_tx_stall,
    output logic [ByteW-1:0] o_tx_byte,
    output logic             o_tx_last,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ByteW-1:0] i_cfg_own_address
);

    logic [ByteW-1:0] r_own_address;
    logic             rx_accept;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    t_reply           push_reply;
    t_reply           head_reply;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = q_full;
    assign rx_accept   = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_address <= i_cfg_own_address;
        end
    end

    cfcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (rx_accept),
        .i_rx_byte     (i_rx_byte),
        .i_own_address (r_own_address),
        .o_push        (push),
        .o_reply       (push_reply)
    );

    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_reply),
        .i_pop   (pop),
        .o_data  (head_reply),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cfcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_reply       (head_reply),
        .i_own_address (r_own_address),
        .o_pop         (pop),
        .o_tx_valid    (o_tx_valid),
        .i_tx_stall    (i_tx_stall),
        .o_tx_byte     (o_tx_byte),
        .o_tx_last     (o_tx_last)
    );

endmodule

// ===== src/cfcr_checker.sv =====
// Port-level assertions of the command frame check and reply core, with bind.
module cfcr_checker
    import cfcr_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_tx_valid,
    input logic             i_tx_stall,
    input logic [ByteW-1:0] o_tx_byte,
    input logic             o_tx_last
);

    a_tx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && i_tx_stall |=> o_tx_valid && $stable(o_tx_byte) && $stable(o_tx_last))
        else $error("tx byte changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tx_valid)
        else $error("tx valid after reset");

    a_reply_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !i_tx_stall && !o_tx_last |=> o_tx_valid)
        else $error("gap inside a reply");

endmodule

bind command_frame_check_and_reply_core cfcr_checker u_cfcr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_tx_valid (o_tx_valid),
    .i_tx_stall (i_tx_stall),
    .o_tx_byte  (o_tx_byte),
    .o_tx_last  (o_tx_last)
);
